// ===== design/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg - shared types and constants for the keyed slot count table
// Operation codes, field widths and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned CountW = 32;

  typedef enum logic [CmdW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } kst_op_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture input word, restart scan
    logic scan;    // issue one slot read
    logic commit;  // update table, load result register
  } kst_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // read of the last slot is being issued
    logic is_clear;   // offered word is a clear-all
  } kst_sts_t;

endpackage

// ===== design/kst_ram.sv =====
// ----------------------------------------------------------------------------
// kst_ram - generic single write port, single read port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/kst_ctrl.sv =====
// ----------------------------------------------------------------------------
// kst_ctrl - sequencer for the keyed slot count table
// Takes an input word, walks the slot scan (a clear skips it), then commits
// once the result register is free and holds the result valid until taken.
// ----------------------------------------------------------------------------
module kst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  kst_pkg::kst_sts_t sts_i,
  output kst_pkg::kst_ctl_t ctl_o
);
  import kst_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // command decode
  always_comb begin
    ctl_o.load   = (state_q == ST_IDLE) && in_valid_i;
    ctl_o.scan   = (state_q == ST_SCAN);
    ctl_o.commit = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);
  end

  // next state and result valid flag
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.is_clear ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (ctl_o.commit) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // a commit always leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |=> out_valid_o)
    else $error("result not presented after commit");

  // a result is never overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit while result register is occupied");

  // no new word is taken while one is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |=> !in_ready_o)
    else $error("input accepted again before the scan");

endmodule

// ===== design/kst_dp.sv =====
// ----------------------------------------------------------------------------
// kst_dp - datapath for the keyed slot count table
// Slot store in RAM with per-slot occupancy flags, one-slot-per-cycle scan
// for the key match and the lowest empty slot, update arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module kst_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [kst_pkg::CmdW-1:0]       cmd_i,
  input  logic [kst_pkg::KeyW-1:0]       item_key_i,
  input  logic [kst_pkg::CountW-1:0]     amount_i,
  input  kst_pkg::kst_ctl_t              ctl_i,
  output kst_pkg::kst_sts_t              sts_o,
  output logic                           ok_o,
  output logic [kst_pkg::CountW-1:0]     stored_count_o,
  output logic                           full_res_o
);
  import kst_pkg::*;

  localparam int unsigned AddrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned OccW  = $clog2(SLOTS + 1);
  localparam int unsigned WordW = KeyW + CountW;

  // captured input word
  kst_op_e             op_q;
  logic [KeyW-1:0]     key_q;
  logic [CountW-1:0]   amt_q;

  // scan state
  logic [AddrW-1:0]    addr_q;
  logic                cmp_v_q;
  logic [AddrW-1:0]    cmp_idx_q;
  logic                hit_q;
  logic [AddrW-1:0]    hit_idx_q;
  logic [CountW-1:0]   hit_cnt_q;
  logic                free_q;
  logic [AddrW-1:0]    free_idx_q;

  // table occupancy
  logic [SLOTS-1:0]    valid_q;
  logic [OccW-1:0]     occ_q, occ_d;

  // result register
  logic                ok_q;
  logic [CountW-1:0]   cnt_q;
  logic                full_q;

  // store
  logic                we;
  logic [AddrW-1:0]    waddr;
  logic [WordW-1:0]    wdata;
  logic [WordW-1:0]    rdata;
  logic [KeyW-1:0]     rd_key;
  logic [CountW-1:0]   rd_cnt;

  // commit logic
  logic                set_v, clr_v, clr_all;
  logic [AddrW-1:0]    v_idx;
  logic                res_ok;
  logic [CountW-1:0]   res_cnt;
  logic [CountW:0]     sum_w;
  logic [CountW-1:0]   sum_sat;
  logic [CountW-1:0]   diff;
  logic                ge;
  logic [CountW-1:0]   cur_cnt;

  kst_ram #(
    .Width (WordW),
    .Depth (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign rd_key = rdata[WordW-1 -: KeyW];
  assign rd_cnt = rdata[CountW-1:0];

  // status to the controller
  always_comb begin
    sts_o.scan_last = (addr_q == AddrW'(SLOTS - 1));
    sts_o.is_clear  = (kst_op_e'(cmd_i) == OP_CLEAR);
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= kst_op_e'(cmd_i);
      key_q <= item_key_i;
      amt_q <= amount_i;
    end
  end

  // scan address and compare pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      cmp_v_q <= 1'b0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      cmp_v_q <= ctl_i.scan;
      if (ctl_i.load) begin
        addr_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (ctl_i.scan && !sts_o.scan_last) begin
          addr_q <= addr_q + AddrW'(1);
        end
        if (cmp_v_q && valid_q[cmp_idx_q] && (rd_key == key_q) && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (cmp_v_q && !valid_q[cmp_idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // slot indices and matched count from the compare stage
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= addr_q;
    if (cmp_v_q && valid_q[cmp_idx_q] && (rd_key == key_q) && !hit_q) begin
      hit_idx_q <= cmp_idx_q;
      hit_cnt_q <= rd_cnt;
    end
    if (cmp_v_q && !valid_q[cmp_idx_q] && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  // saturating add, subtract and compare against the matched count
  assign sum_w   = {1'b0, hit_cnt_q} + {1'b0, amt_q};
  assign sum_sat = sum_w[CountW] ? {CountW{1'b1}} : sum_w[CountW-1:0];
  assign diff    = hit_cnt_q - amt_q;
  assign ge      = (hit_cnt_q >= amt_q);
  assign cur_cnt = hit_q ? hit_cnt_q : '0;

  // update decision
  always_comb begin
    we      = 1'b0;
    waddr   = hit_idx_q;
    wdata   = {key_q, sum_sat};
    set_v   = 1'b0;
    clr_v   = 1'b0;
    clr_all = 1'b0;
    v_idx   = hit_idx_q;
    occ_d   = occ_q;
    res_ok  = 1'b0;
    res_cnt = cur_cnt;
    unique case (op_q)
      OP_ADD: begin
        if ((key_q != '0) && (amt_q != '0)) begin
          if (hit_q) begin
            we      = 1'b1;
            res_ok  = 1'b1;
            res_cnt = sum_sat;
          end else if (free_q) begin
            we      = 1'b1;
            waddr   = free_idx_q;
            wdata   = {key_q, amt_q};
            set_v   = 1'b1;
            v_idx   = free_idx_q;
            occ_d   = occ_q + OccW'(1);
            res_ok  = 1'b1;
            res_cnt = amt_q;
          end
        end
      end
      OP_REMOVE: begin
        if (hit_q && ge) begin
          we      = 1'b1;
          wdata   = {key_q, diff};
          res_ok  = 1'b1;
          res_cnt = diff;
          if (diff == '0) begin
            clr_v = 1'b1;
            occ_d = occ_q - OccW'(1);
          end
        end
      end
      OP_QUERY: begin
        res_ok = hit_q ? ge : (amt_q == '0);
      end
      OP_CLEAR: begin
        clr_all = 1'b1;
        occ_d   = '0;
        res_ok  = 1'b1;
        res_cnt = '0;
      end
      default: res_ok = 1'b0;
    endcase
    if (!ctl_i.commit) begin
      we      = 1'b0;
      set_v   = 1'b0;
      clr_v   = 1'b0;
      clr_all = 1'b0;
      occ_d   = occ_q;
    end
  end

  // occupancy flags and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else begin
      occ_q <= occ_d;
      if (clr_all) begin
        valid_q <= '0;
      end else if (set_v) begin
        valid_q[v_idx] <= 1'b1;
      end else if (clr_v) begin
        valid_q[v_idx] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      ok_q   <= res_ok;
      cnt_q  <= res_cnt;
      full_q <= (occ_d == OccW'(SLOTS));
    end
  end

  assign ok_o           = ok_q;
  assign stored_count_o = cnt_q;
  assign full_res_o     = full_q;

  // occupancy count tracks the flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OccW'($countones(valid_q)))
    else $error("occupancy count out of step with slot flags");

  // count never goes past the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(SLOTS))
    else $error("occupancy count overflow");

  // an occupied slot found by the scan holds a nonzero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hit_q) |-> (hit_cnt_q != '0))
    else $error("matched slot holds a zero count");

endmodule

// ===== design/keyed_slot_count_table.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_count_table - table of keyed counters
// Each slot holds a key and a saturating count; add, remove, query and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word: cmd_i, item_key_i,
//   amount_i. Output channel (out_valid_o/out_ready_i) returns one word per
//   input word: ok_o, stored_count_o, full_res_o.
//   Add, remove and query read every slot from the slot RAM, one slot per
//   cycle through its single read port, then update. Clear skips the scan.
//   One word is in work at a time; in_ready_o is high while the block is
//   idle, also while a finished result still waits in the output register,
//   so the next word's scan overlaps the wait. If the receiver stalls, the
//   next result waits in the write state until the output register is
//   taken; nothing is dropped. Reset empties every slot at once through the
//   per-slot occupancy flags; no clearing pass is needed and the block is
//   ready right after reset.
// ----------------------------------------------------------------------------
module keyed_slot_count_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [kst_pkg::CmdW-1:0]   cmd_i,
  input  logic [kst_pkg::KeyW-1:0]   item_key_i,
  input  logic [kst_pkg::CountW-1:0] amount_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       ok_o,
  output logic [kst_pkg::CountW-1:0] stored_count_o,
  output logic                       full_res_o
);
  import kst_pkg::*;

  kst_ctl_t ctl;
  kst_sts_t sts;

  // sequencer
  kst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // slot store and arithmetic
  kst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .item_key_i     (item_key_i),
    .amount_i       (amount_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .ok_o           (ok_o),
    .stored_count_o (stored_count_o),
    .full_res_o     (full_res_o)
  );

endmodule
